[rtl/usbd_pkg.sv]
// shared types, constants and block number check for the serial block deframer
`default_nettype none
package usbd_pkg;

  localparam int unsigned HUNT_LIMIT_DEF      = 128;
  localparam int unsigned MAX_REPLY_BYTES_DEF = 1024;

  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned LENGTH_W = 11;

  localparam logic [7:0] SYNC_BYTE   = 8'hAB;
  localparam logic [7:0] CMD_RESET   = 8'h31;
  localparam logic [7:0] CMD_DIRECT  = 8'h43;
  localparam logic [7:0] CMD_BASE    = 8'h30;
  localparam logic [7:0] CMD_HIGH    = 8'h89;
  localparam logic [7:0] CMD_SPECIAL = 8'hA0;
  localparam logic [7:0] BLK_SPECIAL = 8'h01;
  localparam logic [7:0] BLK_HIGH    = 8'h09;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SYNC  = 3'd1;
  localparam logic [2:0] ERR_BLOCK = 3'd2;
  localparam logic [2:0] ERR_LEN   = 3'd3;
  localparam logic [2:0] ERR_SEQ   = 3'd4;
  localparam logic [2:0] ERR_SUM   = 3'd5;
  localparam logic [2:0] ERR_OVF   = 3'd6;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_BLOCK  = 6'b000010,
    PH_LENGTH = 6'b000100,
    PH_SEQ    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CSUM   = 6'b100000
  } usbd_phase_t;

  typedef struct packed {
    logic                payload_valid;
    logic [7:0]          payload_byte;
    logic [OFFSET_W-1:0] payload_offset;
    logic                reply_done;
    logic [LENGTH_W-1:0] reply_length;
    logic [2:0]          error_code;
  } usbd_result_t;

  // which block number answers a given request code
  function automatic logic block_ok(input logic [7:0] cmd, input logic [7:0] blk);
    logic ok;
    if (cmd <= CMD_DIRECT) begin
      ok = (cmd >= CMD_BASE) && ((cmd - CMD_BASE) == blk);
    end else if (cmd >= CMD_HIGH) begin
      ok = (cmd == CMD_SPECIAL) ? (blk == BLK_SPECIAL) : (blk == BLK_HIGH);
    end else begin
      ok = 1'b1;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

[rtl/usbd_framer.sv]
// framing state and per-byte decode of the reply blocks
`default_nettype none
module usbd_framer #(
  parameter int unsigned HUNT_LIMIT      = usbd_pkg::HUNT_LIMIT_DEF,
  parameter int unsigned MAX_REPLY_BYTES = usbd_pkg::MAX_REPLY_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          cmd,
  output usbd_pkg::usbd_result_t   result
);
  import usbd_pkg::*;

  localparam int unsigned HW = $clog2(HUNT_LIMIT);
  localparam int unsigned TW = $clog2(MAX_REPLY_BYTES + 1);

  usbd_phase_t   phase, phase_next;
  logic [HW-1:0] hunt_count, hunt_count_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [7:0]    previous_sequence, previous_sequence_next;
  logic          last_block_seen, last_block_seen_next;
  logic [TW-1:0] total_count, total_count_next;

  logic [HW:0]   hunt_cnt;
  logic [7:0]    sum_with_byte;
  logic [8:0]    seq_expect;
  logic [7:0]    bytes_dec;
  logic [31:0]   total_ext;
  logic [2:0]    err;

  always_comb begin
    phase_next             = phase;
    hunt_count_next        = hunt_count;
    bytes_left_next        = bytes_left;
    running_sum_next       = running_sum;
    previous_sequence_next = previous_sequence;
    last_block_seen_next   = last_block_seen;
    total_count_next       = total_count;
    err                    = ERR_NONE;
    result                 = '0;

    hunt_cnt      = {1'b0, hunt_count} + (HW+1)'(1);
    sum_with_byte = running_sum + rx_byte;
    seq_expect    = {1'b0, previous_sequence} + 9'd1;
    bytes_dec     = (bytes_left != 8'd0) ? bytes_left - 8'd1 : bytes_left;
    total_ext     = 32'(total_count);

    unique case (phase)
      PH_HUNT: begin
        // the start byte itself counts toward the limit
        if (hunt_cnt >= (HW+1)'(HUNT_LIMIT)) begin
          err = ERR_SYNC;
        end else if (rx_byte == SYNC_BYTE) begin
          hunt_count_next  = '0;
          running_sum_next = rx_byte;
          phase_next       = PH_BLOCK;
        end else begin
          hunt_count_next = hunt_cnt[HW-1:0];
        end
      end
      PH_BLOCK: begin
        if (!block_ok(cmd, rx_byte)) begin
          err = ERR_BLOCK;
        end else begin
          running_sum_next = sum_with_byte;
          phase_next       = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (rx_byte == 8'd0) begin
          err = ERR_LEN;
        end else begin
          running_sum_next = sum_with_byte;
          bytes_left_next  = rx_byte;
          phase_next       = PH_SEQ;
        end
      end
      PH_SEQ: begin
        // whole previous byte plus one against the low three bits
        if ({6'd0, rx_byte[2:0]} != seq_expect) begin
          err = ERR_SEQ;
        end else begin
          last_block_seen_next   = rx_byte[7];
          previous_sequence_next = rx_byte;
          running_sum_next       = sum_with_byte;
          phase_next             = PH_DATA;
        end
      end
      PH_DATA: begin
        if (total_count >= TW'(MAX_REPLY_BYTES)) begin
          err = ERR_OVF;
        end else begin
          result.payload_valid  = 1'b1;
          result.payload_byte   = rx_byte;
          result.payload_offset = total_ext[OFFSET_W-1:0];
          total_count_next      = total_count + TW'(1);
          running_sum_next      = sum_with_byte;
          bytes_left_next       = bytes_dec;
          if (bytes_dec == 8'd0) begin
            phase_next = PH_CSUM;
          end
        end
      end
      PH_CSUM: begin
        if (sum_with_byte != 8'd0) begin
          err = ERR_SUM;
        end else if (last_block_seen) begin
          result.reply_done      = 1'b1;
          result.reply_length    = total_ext[LENGTH_W-1:0];
          phase_next             = PH_HUNT;
          hunt_count_next        = '0;
          bytes_left_next        = '0;
          running_sum_next       = '0;
          previous_sequence_next = '0;
          last_block_seen_next   = 1'b0;
          total_count_next       = '0;
        end else begin
          phase_next       = PH_HUNT;
          hunt_count_next  = '0;
          running_sum_next = '0;
        end
      end
      default: begin
        err = ERR_SUM;
      end
    endcase

    // any error drops the whole reply
    if (err != ERR_NONE) begin
      phase_next             = PH_HUNT;
      hunt_count_next        = '0;
      bytes_left_next        = '0;
      running_sum_next       = '0;
      previous_sequence_next = '0;
      last_block_seen_next   = 1'b0;
      total_count_next       = '0;
    end
    result.error_code = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      hunt_count        <= '0;
      bytes_left        <= '0;
      running_sum       <= '0;
      previous_sequence <= '0;
      last_block_seen   <= 1'b0;
      total_count       <= '0;
    end else if (step) begin
      phase             <= phase_next;
      hunt_count        <= hunt_count_next;
      bytes_left        <= bytes_left_next;
      running_sum       <= running_sum_next;
      previous_sequence <= previous_sequence_next;
      last_block_seen   <= last_block_seen_next;
      total_count       <= total_count_next;
    end
  end

endmodule
`default_nettype wire

[rtl/ups_serial_block_deframer.sv]
// top level of the serial block deframer: input register, framer, result register
`default_nettype none
// Takes one received serial byte per transfer and gives exactly one result per
// byte: a payload byte with its offset in the whole reply, a reply-complete
// flag with the total length, an error code, or an empty result for any other
// byte (any error drops the reply and the block goes back to hunting for the
// start byte). It sustains one byte per clock cycle while the output is not
// stalled; a byte goes through an input register and then a result register
// before its result is valid. Framing state advances as a byte moves from the
// input register into the result register, through the decode logic. in_ready
// follows out_ready combinationally through the two stages. expected_command is
// always accepted and should only be written while no byte is in flight.
module ups_serial_block_deframer #(
  parameter int unsigned HUNT_LIMIT      = usbd_pkg::HUNT_LIMIT_DEF,
  parameter int unsigned MAX_REPLY_BYTES = usbd_pkg::MAX_REPLY_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [7:0]                    expected_command,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    rx_byte,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic                          payload_valid,
  output      logic [7:0]                    payload_byte,
  output      logic [usbd_pkg::OFFSET_W-1:0] payload_offset,
  output      logic                          reply_done,
  output      logic [usbd_pkg::LENGTH_W-1:0] reply_length,
  output      logic [2:0]                    error_code
);
  import usbd_pkg::*;

  logic [7:0]   cmd;
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_move;
  logic         out_free;
  usbd_result_t step_res;
  usbd_result_t out_res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign s1_move   = s1_valid && out_free;
  assign in_ready  = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= CMD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cmd <= expected_command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  usbd_framer #(
    .HUNT_LIMIT      (HUNT_LIMIT),
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_move),
    .rx_byte (s1_byte),
    .cmd     (cmd),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res <= step_res;
    end
  end

  assign payload_valid  = out_res.payload_valid;
  assign payload_byte   = out_res.payload_byte;
  assign payload_offset = out_res.payload_offset;
  assign reply_done     = out_res.reply_done;
  assign reply_length   = out_res.reply_length;
  assign error_code     = out_res.error_code;

  // an error result carries neither data nor completion
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_NONE) |-> !payload_valid && !reply_done)
    else $error("error result also flags data or completion");

  a_data_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(payload_valid && reply_done))
    else $error("data byte and reply completion in one result");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code != 3'd7)
    else $error("unknown error code");

  // an accepted byte is held in the input register next cycle
  a_in_to_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted byte lost before decode");

  // a decoded byte always lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("decoded byte lost before output");

endmodule
`default_nettype wire
